FILE: hdl/gle_pkg.sv
// Shared types and constants for the GIF LZW encoder.
`default_nettype none
package gle_pkg;

  // Input item kinds (carried on the slave tuser).
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_PIXEL  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // Fixed LZW codes.
  localparam int LZW_CLEAR = 256;
  localparam int LZW_EOI   = 257;
  localparam int FIRST_FREE = 258;
  localparam int START_WIDTH = 9;
  localparam int START_LIMIT = 511;

  typedef enum logic [1:0] {
    EMIT_PREFIX,
    EMIT_CLEAR,
    EMIT_END
  } emit_sel_t;

  typedef struct packed {
    logic      latch;
    logic      init;
    logic      set_first;
    logic      hash;
    logic      probe;
    logic      hit;
    logic      he_set;
    logic      he_val;
    logic      emit;
    emit_sel_t emit_sel;
    logic      drain;
    logic      insert;
    logic      full_reset;
    logic      restart;
    logic      take_pix;
    logic      part;
    logic      flush;
    logic      flush_fin;
    logic      sweep;
  } gle_cmd_t;

  typedef struct packed {
    logic first;
    logic occ;
    logic match;
    logic exhausted;
    logic full;
    logic bits_ge8;
    logic bits_nz;
    logic byte_ok;
    logic sweep_last;
  } gle_sts_t;

endpackage
`default_nettype wire

FILE: hdl/gle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 5003
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/gle_ctrl.sv
// Sequencer for the GIF LZW encoder: item decode, probe loop, emission order.
`default_nettype none
module gle_ctrl
  import gle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_cmd,
  output gle_cmd_t        cmd,
  input  wire gle_sts_t   sts
);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_START, S_HASH, S_RD, S_CMP, S_EMIT, S_DRAIN,
    S_P_UPD, S_C_RESTART, S_F, S_F_END, S_F_PART, S_DONE
  } state_t;

  state_t    state;
  state_t    ret;
  emit_sel_t emit_sel;
  logic      sweep_pend;
  logic      fin;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.emit_sel = emit_sel;
    case (state)
      S_SWEEP:  cmd.sweep = 1'b1;
      S_IDLE:   cmd.latch = in_valid;
      S_START:  cmd.init  = 1'b1;
      S_HASH: begin
        cmd.set_first = sts.first;
        cmd.hash      = !sts.first;
      end
      S_CMP: begin
        if (sts.occ && sts.match) begin
          cmd.hit = 1'b1;
        end else if (!sts.occ) begin
          cmd.he_set = 1'b1;
          cmd.he_val = 1'b1;
        end else if (sts.exhausted) begin
          cmd.he_set = 1'b1;
        end else begin
          cmd.probe = 1'b1;
        end
      end
      S_EMIT:   cmd.emit  = 1'b1;
      S_DRAIN:  cmd.drain = sts.bits_ge8 && sts.byte_ok;
      S_P_UPD: begin
        cmd.insert     = !sts.full;
        cmd.take_pix   = !sts.full;
        cmd.full_reset = sts.full;
      end
      S_C_RESTART: cmd.restart = 1'b1;
      S_F_PART: cmd.part = !sts.bits_nz || sts.byte_ok;
      S_DONE: begin
        cmd.flush     = sts.byte_ok;
        cmd.flush_fin = fin;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      ret        <= S_DONE;
      emit_sel   <= EMIT_PREFIX;
      sweep_pend <= 1'b0;
      fin        <= 1'b0;
    end else begin
      case (state)
        S_SWEEP: begin
          if (sts.sweep_last) begin
            state      <= S_IDLE;
            sweep_pend <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            fin <= (in_cmd == CMD_FINISH);
            case (in_cmd)
              CMD_START:  state <= S_START;
              CMD_PIXEL:  state <= S_HASH;
              CMD_FINISH: state <= S_F;
              default:    state <= S_DONE;
            endcase
          end
        end
        S_START: begin
          emit_sel   <= EMIT_CLEAR;
          ret        <= S_DONE;
          sweep_pend <= 1'b1;
          state      <= S_EMIT;
        end
        S_HASH:   state <= sts.first ? S_DONE : S_RD;
        S_RD:     state <= S_CMP;
        S_CMP: begin
          if (sts.occ && sts.match) begin
            state <= S_DONE;
          end else if (!sts.occ || sts.exhausted) begin
            emit_sel <= EMIT_PREFIX;
            ret      <= S_P_UPD;
            state    <= S_EMIT;
          end else begin
            state <= S_RD;
          end
        end
        S_EMIT:   state <= S_DRAIN;
        S_DRAIN: begin
          if (!sts.bits_ge8) begin
            state <= ret;
          end
        end
        S_P_UPD: begin
          if (sts.full) begin
            emit_sel <= EMIT_CLEAR;
            ret      <= S_C_RESTART;
            state    <= S_EMIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_C_RESTART: begin
          sweep_pend <= 1'b1;
          state      <= S_DONE;
        end
        S_F: begin
          if (sts.first) begin
            state <= S_F_END;
          end else begin
            emit_sel <= EMIT_PREFIX;
            ret      <= S_F_END;
            state    <= S_EMIT;
          end
        end
        S_F_END: begin
          emit_sel <= EMIT_END;
          ret      <= S_F_PART;
          state    <= S_EMIT;
        end
        S_F_PART: begin
          if (!sts.bits_nz || sts.byte_ok) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (sts.byte_ok) begin
            state <= sweep_pend ? S_SWEEP : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/gle_dp.sv
// Datapath: hash dictionary, coder state, bit packer and output stage.
`default_nettype none
module gle_dp
  import gle_pkg::*;
#(
  parameter int TABLE_SLOTS   = 5003,
  parameter int MAX_CODE_BITS = 12,
  parameter int PACKET_BYTES  = 255
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] pix_in,
  input  wire gle_cmd_t   cmd,
  output gle_sts_t        sts,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_pe,
  output logic            out_last
);

  localparam int SW  = $clog2(TABLE_SLOTS);
  localparam int HW  = SW + 1;
  localparam int PW  = $clog2(TABLE_SLOTS + 1);
  localparam int MCB = MAX_CODE_BITS;
  localparam int NFW = MCB + 1;
  localparam int KW  = MCB + 8;
  localparam int DW  = KW + MCB;
  localparam int AW  = 24;
  localparam logic [NFW-1:0] CODE_SPACE = NFW'(1) << MCB;

  logic [7:0]     pix;
  logic [MCB-1:0] prefix;
  logic           awaiting;
  logic [NFW-1:0] next_free;
  logic [3:0]     code_width;
  logic [NFW-1:0] width_limit;
  logic [AW-1:0]  bit_accum;
  logic [4:0]     bit_count;
  logic [7:0]     packet_fill;
  logic [SW-1:0]  slot;
  logic [SW-1:0]  disp;
  logic [PW-1:0]  probes;
  logic [SW-1:0]  clr_addr;
  logic           hit_empty;
  logic [7:0]     pend_byte;
  logic           pend_pe;
  logic           pend_valid;

  logic           ram_we;
  logic [SW-1:0]  ram_waddr;
  logic [DW-1:0]  ram_wdata;
  logic [DW-1:0]  ram_rdata;

  gle_ram #(.WIDTH(DW), .DEPTH(TABLE_SLOTS)) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  logic [KW-1:0]  key;
  logic [MCB-1:0] rcode;
  logic [HW-1:0]  h_raw, h_mod, p_next;
  logic [MCB-1:0] code_sel;
  logic [AW-1:0]  masked;
  logic [3:0]     cw_inc;
  logic [7:0]     fill_inc;
  logic           push, byte_pe, out_free;

  assign key   = {prefix, pix};
  assign rcode = ram_rdata[MCB-1:0];
  assign h_raw = (HW'(pix) << (MCB - 8)) + HW'(prefix);
  assign h_mod = (h_raw >= HW'(TABLE_SLOTS)) ? h_raw - HW'(TABLE_SLOTS) : h_raw;
  assign p_next = ({1'b0, slot} >= {1'b0, disp}) ? {1'b0, slot} - {1'b0, disp}
                                                 : {1'b0, slot} + HW'(TABLE_SLOTS) - {1'b0, disp};

  always_comb begin
    case (cmd.emit_sel)
      EMIT_PREFIX: code_sel = prefix;
      EMIT_CLEAR:  code_sel = MCB'(LZW_CLEAR);
      EMIT_END:    code_sel = MCB'(LZW_EOI);
      default:     code_sel = prefix;
    endcase
  end

  assign masked   = AW'(code_sel) & ((AW'(1) << code_width) - AW'(1));
  assign cw_inc   = code_width + 4'd1;
  assign fill_inc = packet_fill + 8'd1;
  assign byte_pe  = (fill_inc >= 8'(PACKET_BYTES));
  assign push     = cmd.drain || (cmd.part && bit_count != 5'd0);
  assign out_free = !out_valid || out_ready;

  assign ram_we    = cmd.sweep || (cmd.insert && hit_empty);
  assign ram_waddr = cmd.sweep ? clr_addr : slot;
  assign ram_wdata = cmd.sweep ? '0 : {key, next_free[MCB-1:0]};

  always_comb begin
    sts            = '0;
    sts.first      = awaiting;
    sts.occ        = (rcode != '0);
    sts.match      = (ram_rdata[DW-1:MCB] == key);
    sts.exhausted  = (probes == PW'(TABLE_SLOTS));
    sts.full       = (next_free >= CODE_SPACE);
    sts.bits_ge8   = (bit_count >= 5'd8);
    sts.bits_nz    = (bit_count != 5'd0);
    sts.byte_ok    = !pend_valid || out_free;
    sts.sweep_last = (clr_addr == SW'(TABLE_SLOTS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix      <= '0;
      awaiting    <= 1'b1;
      next_free   <= NFW'(FIRST_FREE);
      code_width  <= 4'(START_WIDTH);
      width_limit <= NFW'(START_LIMIT);
      bit_accum   <= '0;
      bit_count   <= '0;
      packet_fill <= '0;
      clr_addr    <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.latch) begin
        pix <= pix_in;
      end
      if (cmd.sweep) begin
        clr_addr <= sts.sweep_last ? '0 : clr_addr + SW'(1);
      end
      if (cmd.init) begin
        prefix      <= '0;
        awaiting    <= 1'b1;
        next_free   <= NFW'(FIRST_FREE);
        code_width  <= 4'(START_WIDTH);
        width_limit <= NFW'(START_LIMIT);
        bit_accum   <= '0;
        bit_count   <= '0;
        packet_fill <= '0;
      end
      if (cmd.set_first) begin
        prefix   <= MCB'(pix);
        awaiting <= 1'b0;
      end
      if (cmd.hash) begin
        slot   <= h_mod[SW-1:0];
        disp   <= (h_mod == '0) ? SW'(1) : SW'(HW'(TABLE_SLOTS) - h_mod);
        probes <= '0;
      end
      if (cmd.probe) begin
        slot   <= p_next[SW-1:0];
        probes <= probes + PW'(1);
      end
      if (cmd.hit) begin
        prefix <= rcode;
      end
      if (cmd.he_set) begin
        hit_empty <= cmd.he_val;
      end
      if (cmd.emit) begin
        bit_accum <= bit_accum | (masked << bit_count);
        bit_count <= bit_count + 5'(code_width);
        if (next_free > width_limit) begin
          if (code_width < 4'(MCB)) begin
            code_width  <= cw_inc;
            width_limit <= (cw_inc == 4'(MCB)) ? CODE_SPACE
                                               : (NFW'(1) << cw_inc) - NFW'(1);
          end else begin
            width_limit <= CODE_SPACE;
          end
        end
      end
      if (cmd.drain) begin
        bit_accum <= bit_accum >> 8;
        bit_count <= bit_count - 5'd8;
      end
      if (cmd.insert && hit_empty) begin
        next_free <= next_free + NFW'(1);
      end
      if (cmd.full_reset) begin
        next_free <= NFW'(FIRST_FREE);
      end
      if (cmd.take_pix || cmd.restart) begin
        prefix <= MCB'(pix);
      end
      if (cmd.restart) begin
        code_width  <= 4'(START_WIDTH);
        width_limit <= NFW'(START_LIMIT);
      end
      if (push) begin
        packet_fill <= byte_pe ? 8'd0 : fill_inc;
        pend_byte   <= bit_accum[7:0];
        pend_pe     <= byte_pe;
        pend_valid  <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
          out_byte  <= pend_byte;
          out_pe    <= pend_pe;
          out_last  <= 1'b0;
        end
      end
      if (cmd.part) begin
        bit_accum   <= '0;
        bit_count   <= '0;
        packet_fill <= '0;
        awaiting    <= 1'b1;
      end
      if (cmd.flush && pend_valid) begin
        out_valid  <= 1'b1;
        out_byte   <= pend_byte;
        out_pe     <= pend_pe || cmd.flush_fin;
        out_last   <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  a_drain_full: assert property (@(posedge clk) disable iff (rst)
    cmd.drain |-> bit_count >= 5'd8) else $error("drain without a whole byte");
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.insert && hit_empty) |-> next_free < CODE_SPACE) else $error("insert into full table");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (push && pend_valid) |-> out_free) else $error("output beat overwritten");
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (code_width >= 4'(START_WIDTH) && code_width <= 4'(MCB)))
    else $error("code width out of range");

endmodule
`default_nettype wire

FILE: hdl/gif_lzw_encoder.sv
// Top level of the GIF LZW encoder: stream ports, sequencer and datapath.
// Pixel hit on the primary slot: S_HASH, S_RD, S_CMP and S_DONE from accept to
//   ready; a further probe repeats S_RD/S_CMP, one registered dictionary read.
// A miss adds S_P_UPD for the table update (and S_C_RESTART with a full-table
//   clear), S_EMIT per code and an S_DRAIN step per byte, stalled by tready.
// Start, a full-table clear and rst (synchronous, active high) all lead to a
//   dictionary sweep over TABLE_SLOTS slots (5003 by default); no beat taken.
`default_nettype none
module gif_lzw_encoder
  import gle_pkg::*;
#(
  parameter int TABLE_SLOTS   = 5003,
  parameter int MAX_CODE_BITS = 12,
  parameter int PACKET_BYTES  = 255
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] pixel_index
  input  wire logic [1:0] s_axis_tuser,   // [1:0] command
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] data_byte
  output logic [0:0]      m_axis_tuser,   // [0] packet_end
  output logic            m_axis_tlast
);

  gle_cmd_t cmd;
  gle_sts_t sts;

  // Sequencer: decodes each input beat and walks the probe/emit steps.
  gle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: dictionary RAM, bit packer, one held byte plus output register,
  // so the last byte of an item can be flagged once the item is done.
  gle_dp #(
    .TABLE_SLOTS   (TABLE_SLOTS),
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .PACKET_BYTES  (PACKET_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_pe    (m_axis_tuser[0]),
    .out_last  (m_axis_tlast)
  );

endmodule
`default_nettype wire
